/* rtl/psad_pkg.sv */
// psad_pkg: shared types, constants and register indexes for the pen stroke
// activity detector. No dependencies.
package psad_pkg;

    localparam int MAX_STROKE_FRAMES = 8192;
    localparam int CNT_W = $clog2(MAX_STROKE_FRAMES + 1);

    // register indexes
    localparam logic [2:0] REG_JERK_IMPACT = 3'd0;
    localparam logic [2:0] REG_JERK_STILL  = 3'd1;
    localparam logic [2:0] REG_GYRO_MOVING = 3'd2;
    localparam logic [2:0] REG_GYRO_STILL  = 3'd3;
    localparam logic [2:0] REG_LIFT_QUIET  = 3'd4;
    localparam logic [2:0] REG_END_QUIET   = 3'd5;
    localparam logic [2:0] REG_TAIL_KEEP   = 3'd6;
    localparam logic [2:0] REG_MIN_STROKE  = 3'd7;

    // pen modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_WRITING = 2'd1;
    localparam logic [1:0] MODE_LIFTED  = 2'd2;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } sample_t;

    typedef struct packed {
        logic [1:0]  pen_mode_now;
        logic        sample_recorded;
        logic        stroke_finished;
        logic [13:0] trimmed_length;
        logic        stroke_accepted;
        logic        length_saturated;
    } result_t;

    // front to back: magnitudes of one sample
    typedef struct packed {
        logic [16:0] amag;
        logic [16:0] gmag;
    } mags_t;

    typedef struct packed {
        logic [22:0] jerk_impact_level;
        logic [22:0] jerk_still_level;
        logic [15:0] gyro_moving_level;
        logic [15:0] gyro_still_level;
        logic [9:0]  lift_quiet_limit;
        logic [9:0]  end_quiet_limit;
        logic [9:0]  tail_keep_frames;
        logic [12:0] min_stroke_frames;
    } cfg_t;

endpackage

/* rtl/psad_front.sv */
// psad_front: accepts samples, computes accel and gyro magnitudes with one
// shared two-bit-per-cycle square root unit. Depends on psad_pkg.
module psad_front
    import psad_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  sample_t in_data,
    output logic    q_valid,
    input  logic    q_stall,
    output mags_t   q_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQRT = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic        second_reg, second_next;   // 0: accel, 1: gyro
    logic [4:0]  step_reg, step_next;       // 18 steps over 36 bits
    logic [35:0] rem_reg, rem_next;
    logic [17:0] root_reg, root_next;
    logic [35:0] rad_reg, rad_next;
    logic [33:0] gsq_reg, gsq_next;
    logic [16:0] amag_reg, amag_next;
    logic [16:0] gmag_reg, gmag_next;

    logic [15:0] ax, ay, az, gx, gy, gz;
    logic [35:0] trial;
    logic [35:0] rem_sh;

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        abs16 = v[15] ? 16'(-v) : 16'(v);
    endfunction

    assign ax = abs16(in_data.accel_x);
    assign ay = abs16(in_data.accel_y);
    assign az = abs16(in_data.accel_z);
    assign gx = abs16(in_data.gyro_x);
    assign gy = abs16(in_data.gyro_y);
    assign gz = abs16(in_data.gyro_z);

    assign in_stall = (state_reg != ST_IDLE);
    assign q_valid  = (state_reg == ST_DONE);
    assign q_data   = '{amag: amag_reg, gmag: gmag_reg};

    // restoring square root, two radicand bits per cycle
    assign rem_sh = {rem_reg[33:0], rad_reg[35:34]};
    assign trial  = {16'd0, root_reg, 2'b01};

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        rad_next    = rad_reg;
        gsq_next    = gsq_reg;
        amag_next   = amag_reg;
        gmag_next   = gmag_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // squares taken once at accept, summed in 36 bits (accel) and 34 bits (gyro)
                    rad_next = 36'(32'(ax) * 32'(ax)) + 36'(32'(ay) * 32'(ay))
                             + 36'(32'(az) * 32'(az));
                    gsq_next = 34'(32'(gx) * 32'(gx)) + 34'(32'(gy) * 32'(gy))
                             + 34'(32'(gz) * 32'(gz));
                    rem_next    = '0;
                    root_next   = '0;
                    step_next   = '0;
                    second_next = 1'b0;
                    state_next  = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                rad_next = {rad_reg[33:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[16:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[16:0], 1'b0};
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd17)
                begin
                    if (!second_reg)
                    begin
                        amag_next   = root_next[16:0];
                        rad_next    = {2'b00, gsq_reg};
                        rem_next    = '0;
                        root_next   = '0;
                        step_next   = '0;
                        second_next = 1'b1;
                    end
                    else
                    begin
                        gmag_next  = root_next[16:0];
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!q_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            second_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= rad_next;
        gsq_reg  <= gsq_next;
        amag_reg <= amag_next;
        gmag_reg <= gmag_next;
    end

endmodule

/* rtl/psad_queue.sv */
// psad_queue: two-entry queue of magnitude pairs between front and back.
// Depends on psad_pkg.
module psad_queue
    import psad_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_stall,
    input  mags_t wr_data,
    output logic  rd_valid,
    input  logic  rd_stall,
    output mags_t rd_data
);

    mags_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

/* rtl/psad_back.sv */
// psad_back: jerk filter, pen state machine, stroke counting and trim.
// Depends on psad_pkg.
module psad_back
    import psad_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_valid,
    output logic    q_stall,
    input  mags_t   q_data,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_JERK = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FSM  = 2'd3;

    localparam int NUM_W = 26;   // 3*jerk + 7*prev below 2^26
    localparam logic [26:0] DIV10_RECIP = 27'd107374183;   // ceil(2^30 / 10)

    logic [1:0]       st_reg, st_next;
    logic [1:0]       mode_reg, mode_next;
    logic [10:0]      quiet_reg, quiet_next;
    logic [16:0]      pamag_reg, pamag_next;
    logic [22:0]      psj_reg, psj_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] last_reg, last_next;
    logic             ov_reg, ov_next;
    result_t          res_reg, res_next;

    logic [16:0]      gmag_reg, gmag_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [22:0]      quo_reg, quo_next;

    logic [16:0]      diff;
    logic [52:0]      prod;
    logic             out_valid_reg_busy;
    logic             active, quiet, rec_ok, rec, fin, sat;
    logic [CNT_W-1:0] cnt_rec, last_rec;
    logic [CNT_W:0]   tsum;
    logic [CNT_W-1:0] trimmed;
    logic [22:0]      sj;

    assign out_valid_reg_busy = ov_reg && out_stall;
    assign q_stall = (st_reg != ST_IDLE) || (out_valid_reg_busy);
    assign out_valid = ov_reg;
    assign out_data  = res_reg;

    assign diff = (q_data.amag > pamag_reg) ? q_data.amag - pamag_reg
                                            : pamag_reg - q_data.amag;
    // divide by ten through a reciprocal multiply, exact for numerators below 2^26
    assign prod = 53'(num_reg) * 53'(DIV10_RECIP);
    assign sj   = quo_reg;

    always_comb
    begin
        active = (sj > cfg.jerk_impact_level) || (gmag_reg > 17'(cfg.gyro_moving_level));
        quiet  = (sj < cfg.jerk_still_level) && (gmag_reg < 17'(cfg.gyro_still_level));
        rec_ok = (cnt_reg < CNT_W'(MAX_STROKE_FRAMES));
        cnt_rec  = cnt_reg;
        last_rec = last_reg;
        if (mode_reg == MODE_IDLE)
        begin
            cnt_rec  = '0;
            last_rec = '0;
        end
        rec = (mode_reg != MODE_IDLE) || active;
        rec = rec && ((mode_reg == MODE_IDLE) || rec_ok);
        if (rec)
        begin
            cnt_rec = cnt_rec + CNT_W'(1);
            if (gmag_reg > 17'(cfg.gyro_still_level))
                last_rec = cnt_rec;
        end
        tsum = {1'b0, last_rec} + (CNT_W+1)'(cfg.tail_keep_frames);
        trimmed = cnt_rec;
        if ((last_rec != '0) && (tsum < {1'b0, cnt_rec}))
            trimmed = tsum[CNT_W-1:0];
        sat = (cnt_rec >= CNT_W'(MAX_STROKE_FRAMES));
    end

    always_comb
    begin
        st_next    = st_reg;
        mode_next  = mode_reg;
        quiet_next = quiet_reg;
        pamag_next = pamag_reg;
        psj_next   = psj_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        ov_next    = ov_reg && out_stall;
        res_next   = res_reg;
        gmag_next  = gmag_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        fin        = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid && !q_stall)
                begin
                    gmag_next  = q_data.gmag;
                    pamag_next = q_data.amag;
                    // jerk*100 below 2^24
                    num_next   = NUM_W'(24'(diff) * 24'd100);
                    st_next    = ST_JERK;
                end
            end
            ST_JERK:
            begin
                num_next = NUM_W'(num_reg[23:0] * 26'd3) + NUM_W'(psj_reg * 26'd7);
                st_next  = ST_DIV;
            end
            ST_DIV:
            begin
                quo_next = prod[52:30];
                st_next  = ST_FSM;
            end
            ST_FSM:
            begin
                psj_next  = sj;
                cnt_next  = cnt_rec;
                last_next = last_rec;
                unique case (mode_reg)
                    MODE_WRITING:
                    begin
                        if (quiet)
                        begin
                            quiet_next = quiet_reg + 11'd1;
                            if (quiet_next > 11'(cfg.lift_quiet_limit))
                            begin
                                mode_next  = MODE_LIFTED;
                                quiet_next = '0;
                            end
                        end
                        else
                            quiet_next = '0;
                    end
                    MODE_LIFTED:
                    begin
                        if (active)
                        begin
                            mode_next  = MODE_WRITING;
                            quiet_next = '0;
                        end
                        else
                        begin
                            quiet_next = quiet_reg + 11'd1;
                            if (quiet_next > 11'(cfg.end_quiet_limit))
                            begin
                                mode_next  = MODE_IDLE;
                                quiet_next = '0;
                                fin        = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                        if (active)
                        begin
                            mode_next  = MODE_WRITING;
                            quiet_next = '0;
                        end
                        else
                        begin
                            cnt_next  = cnt_reg;
                            last_next = last_reg;
                        end
                    end
                endcase
                if (fin)
                begin
                    cnt_next  = '0;
                    last_next = '0;
                end
                res_next.pen_mode_now     = mode_next;
                res_next.sample_recorded  = rec;
                res_next.stroke_finished  = fin;
                res_next.trimmed_length   = fin ? 14'(trimmed) : 14'd0;
                res_next.stroke_accepted  = fin && (trimmed > CNT_W'(cfg.min_stroke_frames));
                res_next.length_saturated = (mode_reg == MODE_IDLE && !active)
                                          ? (cnt_reg >= CNT_W'(MAX_STROKE_FRAMES)) : sat;
                ov_next = 1'b1;
                st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            mode_reg  <= MODE_IDLE;
            quiet_reg <= '0;
            pamag_reg <= 17'd4096;
            psj_reg   <= '0;
            cnt_reg   <= '0;
            last_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            mode_reg  <= mode_next;
            quiet_reg <= quiet_next;
            pamag_reg <= pamag_next;
            psj_reg   <= psj_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        gmag_reg <= gmag_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
    end

endmodule

/* rtl/pen_stroke_activity_detector.sv */
// Top level of the pen stroke activity detector: config registers, front,
// queue and back. Depends on psad_pkg, psad_front, psad_queue, psad_back.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall    in_data  (sample_t)
//   out       output     out_valid / out_stall  out_data (result_t)
//   cfg       input      cfg_we                 cfg_index, cfg_data
//
// Front: two 18-step square roots per sample in one unit.
// Back: accept, scale, reciprocal divide by ten, state update, in that order.
// The queue lets the front work on the next sample while the back finishes.
// Reset is async, active low; control and config registers go to defaults.
// A stalled output holds its result and stops the back after one item.
module pen_stroke_activity_detector
    import psad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  sample_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output result_t     out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [22:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  fq_valid, fq_stall, qb_valid, qb_stall;
    mags_t fq_data, qb_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.jerk_impact_level <= 23'd49152;
            cfg_reg.jerk_still_level  <= 23'd8192;
            cfg_reg.gyro_moving_level <= 16'd240;
            cfg_reg.gyro_still_level  <= 16'd80;
            cfg_reg.lift_quiet_limit  <= 10'd50;
            cfg_reg.end_quiet_limit   <= 10'd200;
            cfg_reg.tail_keep_frames  <= 10'd70;
            cfg_reg.min_stroke_frames <= 13'd20;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_JERK_IMPACT: cfg_reg.jerk_impact_level <= cfg_data;
                REG_JERK_STILL:  cfg_reg.jerk_still_level  <= cfg_data;
                REG_GYRO_MOVING: cfg_reg.gyro_moving_level <= cfg_data[15:0];
                REG_GYRO_STILL:  cfg_reg.gyro_still_level  <= cfg_data[15:0];
                REG_LIFT_QUIET:  cfg_reg.lift_quiet_limit  <= cfg_data[9:0];
                REG_END_QUIET:   cfg_reg.end_quiet_limit   <= cfg_data[9:0];
                REG_TAIL_KEEP:   cfg_reg.tail_keep_frames  <= cfg_data[9:0];
                REG_MIN_STROKE:  cfg_reg.min_stroke_frames <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    psad_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .q_valid(fq_valid), .q_stall(fq_stall), .q_data(fq_data)
    );

    psad_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_data(fq_data),
        .rd_valid(qb_valid), .rd_stall(qb_stall), .rd_data(qb_data)
    );

    psad_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .q_valid(qb_valid), .q_stall(qb_stall), .q_data(qb_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

`ifndef NO_ASSERTIONS
    // a finished stroke always returns the pen to idle
    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.stroke_finished |-> out_data.pen_mode_now == MODE_IDLE)
        else $error("finished stroke not idle");
    // trim fields are zero unless a stroke finished
    a_trim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.stroke_finished |->
            out_data.trimmed_length == 14'd0 && !out_data.stroke_accepted)
        else $error("trim fields set without finish");
    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
`endif

endmodule

/* verif/pen_stroke_activity_detector_test.sv */
// Testbench for pen_stroke_activity_detector: random IMU sample streams with
// a scoreboard that predicts every result. Depends on psad_pkg and the RTL.
module pen_stroke_activity_detector_test;
    import psad_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 120;
    localparam int RANDOM_ITEMS   = 1900;

    // Sample kinds used when building strokes
    typedef enum int {
        KIND_STILL,
        KIND_SPIN,
        KIND_JOLT,
        KIND_NOISE
    } sample_kind_e;

    // Detector predictor and expected-result store
    class stroke_scoreboard;
        cfg_t            cfg;
        logic [1:0]      mode;
        int unsigned     quiet_frames;
        int unsigned     last_accel_mag;
        int unsigned     last_jerk_avg;
        int unsigned     frame_count;
        int unsigned     last_spin_pos;
        result_t         expected_q[$];
        int              errors;
        int              samples_seen;
        int              strokes_done;
        int              strokes_kept;
        int              full_seen;

        function new();
            cfg.jerk_impact_level = 23'd49152;
            cfg.jerk_still_level  = 23'd8192;
            cfg.gyro_moving_level = 16'd240;
            cfg.gyro_still_level  = 16'd80;
            cfg.lift_quiet_limit  = 10'd50;
            cfg.end_quiet_limit   = 10'd200;
            cfg.tail_keep_frames  = 10'd70;
            cfg.min_stroke_frames = 13'd20;
            mode = MODE_IDLE;
            last_accel_mag = 4096;
        endfunction

        function void set_reg(logic [2:0] idx, logic [22:0] v);
            case (idx)
                REG_JERK_IMPACT: cfg.jerk_impact_level = v;
                REG_JERK_STILL:  cfg.jerk_still_level  = v;
                REG_GYRO_MOVING: cfg.gyro_moving_level = v[15:0];
                REG_GYRO_STILL:  cfg.gyro_still_level  = v[15:0];
                REG_LIFT_QUIET:  cfg.lift_quiet_limit  = v[9:0];
                REG_END_QUIET:   cfg.end_quiet_limit   = v[9:0];
                REG_TAIL_KEEP:   cfg.tail_keep_frames  = v[9:0];
                default:         cfg.min_stroke_frames = v[12:0];
            endcase
        endfunction

        // Floor square root of the sum of squares of three axes
        function int unsigned vec_len(logic signed [15:0] a, logic signed [15:0] b,
                                      logic signed [15:0] c);
            longint unsigned n, root, bitv;
            longint ia, ib, ic;
            ia = a; ib = b; ic = c;
            if (ia < 0) ia = -ia;
            if (ib < 0) ib = -ib;
            if (ic < 0) ic = -ic;
            n = ia * ia + ib * ib + ic * ic;
            root = 0;
            bitv = 64'd1 << 34;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0)
            begin
                if (n >= root + bitv)
                begin
                    n = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root >>= 1;
                bitv >>= 2;
            end
            return int'(root);
        endfunction

        function bit add_frame(int unsigned gmag);
            if (frame_count >= MAX_STROKE_FRAMES) return 0;
            frame_count++;
            if (gmag > cfg.gyro_still_level) last_spin_pos = frame_count;
            return 1;
        endfunction

        // Accepted input transfer: predict its result
        function void note_sample(sample_t s);
            int unsigned amag, gmag, diff, trimmed;
            longint unsigned jerk;
            bit active, quiet, rec, fin;
            result_t r;
            amag = vec_len(s.accel_x, s.accel_y, s.accel_z);
            gmag = vec_len(s.gyro_x, s.gyro_y, s.gyro_z);
            diff = (amag > last_accel_mag) ? amag - last_accel_mag : last_accel_mag - amag;
            jerk = longint'(diff) * 100;
            last_jerk_avg = int'((3 * jerk + 7 * longint'(last_jerk_avg)) / 10);
            last_accel_mag = amag;
            active = (last_jerk_avg > cfg.jerk_impact_level) || (gmag > cfg.gyro_moving_level);
            quiet = (last_jerk_avg < cfg.jerk_still_level) && (gmag < cfg.gyro_still_level);
            rec = 0; fin = 0; trimmed = 0;
            samples_seen++;
            case (mode)
                MODE_WRITING:
                begin
                    rec = add_frame(gmag);
                    if (quiet)
                    begin
                        quiet_frames++;
                        if (quiet_frames > cfg.lift_quiet_limit)
                        begin
                            mode = MODE_LIFTED;
                            quiet_frames = 0;
                        end
                    end
                    else
                        quiet_frames = 0;
                end
                MODE_LIFTED:
                begin
                    rec = add_frame(gmag);
                    if (active)
                    begin
                        mode = MODE_WRITING;
                        quiet_frames = 0;
                    end
                    else
                    begin
                        quiet_frames++;
                        if (quiet_frames > cfg.end_quiet_limit)
                        begin
                            mode = MODE_IDLE;
                            quiet_frames = 0;
                            fin = 1;
                            trimmed = frame_count;
                            if (last_spin_pos != 0 &&
                                last_spin_pos + cfg.tail_keep_frames < trimmed)
                                trimmed = last_spin_pos + cfg.tail_keep_frames;
                        end
                    end
                end
                default:
                begin
                    mode = MODE_IDLE;
                    if (active)
                    begin
                        mode = MODE_WRITING;
                        quiet_frames = 0;
                        frame_count = 0;
                        last_spin_pos = 0;
                        rec = add_frame(gmag);
                    end
                end
            endcase
            r.length_saturated = (frame_count >= MAX_STROKE_FRAMES);
            if (fin)
            begin
                frame_count = 0;
                last_spin_pos = 0;
            end
            r.pen_mode_now = mode;
            r.sample_recorded = rec;
            r.stroke_finished = fin;
            r.trimmed_length = fin ? 14'(trimmed) : 14'd0;
            r.stroke_accepted = fin && (trimmed > cfg.min_stroke_frames);
            if (fin) strokes_done++;
            if (r.stroke_accepted) strokes_kept++;
            if (r.length_saturated) full_seen++;
            expected_q.insert(expected_q.size(), r);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 30) $display("mismatch: %s", what);
        endtask

        // Output transfer: compare against the oldest prediction
        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.pen_mode_now !== want.pen_mode_now)
                report($sformatf("pen_mode_now %0d, want %0d", got.pen_mode_now,
                                 want.pen_mode_now));
            if (got.sample_recorded !== want.sample_recorded)
                report($sformatf("sample_recorded %b, want %b", got.sample_recorded,
                                 want.sample_recorded));
            if (got.stroke_finished !== want.stroke_finished)
                report($sformatf("stroke_finished %b, want %b", got.stroke_finished,
                                 want.stroke_finished));
            if (got.trimmed_length !== want.trimmed_length)
                report($sformatf("trimmed_length %0d, want %0d", got.trimmed_length,
                                 want.trimmed_length));
            if (got.stroke_accepted !== want.stroke_accepted)
                report($sformatf("stroke_accepted %b, want %b", got.stroke_accepted,
                                 want.stroke_accepted));
            if (got.length_saturated !== want.length_saturated)
                report($sformatf("length_saturated %b, want %b", got.length_saturated,
                                 want.length_saturated));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    sample_t     in_data;
    logic        out_valid;
    logic        out_stall;
    result_t     out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [22:0] cfg_data;

    stroke_scoreboard sb = new();
    bit calm;          // no idling on either side while set
    int watchdog_count;
    int sent;

    pen_stroke_activity_detector dut (.*);

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Output side: random stall, check every transfer
    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 38);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            watchdog_count <= 0;
        else if (watchdog_count >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            watchdog_count <= watchdog_count + 1;
    end

    // One input transfer, with random idle cycles ahead of it
    task send(sample_t s);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= s;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_sample(s);
        sent++;
    endtask

    // Stop sending and wait for every pending result
    task drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_cfg(cfg_t c);
        logic [22:0] vals[8];
        vals[REG_JERK_IMPACT] = c.jerk_impact_level;
        vals[REG_JERK_STILL]  = 23'(c.jerk_still_level);
        vals[REG_GYRO_MOVING] = 23'(c.gyro_moving_level);
        vals[REG_GYRO_STILL]  = 23'(c.gyro_still_level);
        vals[REG_LIFT_QUIET]  = 23'(c.lift_quiet_limit);
        vals[REG_END_QUIET]   = 23'(c.end_quiet_limit);
        vals[REG_TAIL_KEEP]   = 23'(c.tail_keep_frames);
        vals[REG_MIN_STROKE]  = 23'(c.min_stroke_frames);
        @(negedge clk);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            sb.set_reg(3'(i), vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] signed_span(int lo, int hi);
        int v;
        v = $urandom_range(hi, lo);
        return 16'($urandom_range(1) ? v : -v);
    endfunction

    function automatic sample_t make_sample(sample_kind_e kind);
        sample_t s;
        s = sample_t'({$urandom, $urandom, $urandom});
        case (kind)
            KIND_STILL:
            begin
                s.accel_x = 16'(4096 + $urandom_range(3));
                s.accel_y = signed_span(0, 2);
                s.accel_z = signed_span(0, 2);
                s.gyro_x = signed_span(0, 40);
                s.gyro_y = signed_span(0, 40);
                s.gyro_z = signed_span(0, 40);
            end
            KIND_SPIN:
            begin
                s.gyro_x = signed_span(300, 32767);
                s.gyro_y = signed_span(0, 2000);
                s.gyro_z = signed_span(0, 2000);
            end
            // large accel swing with a still gyro
            KIND_JOLT:
            begin
                s.gyro_x = signed_span(0, 30);
                s.gyro_y = signed_span(0, 30);
                s.gyro_z = signed_span(0, 30);
            end
            default: ;
        endcase
        return s;
    endfunction

    // One stroke: a burst of motion, then a still tail
    task stroke(int burst, int tail);
        int pick;
        for (int i = 0; i < burst; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45) send(make_sample(KIND_SPIN));
            else if (pick < 65) send(make_sample(KIND_JOLT));
            else if (pick < 85) send(make_sample(KIND_STILL));
            else send(make_sample(KIND_NOISE));
        end
        for (int i = 0; i < tail; i++)
            send(make_sample($urandom_range(19) == 0 ? KIND_NOISE : KIND_STILL));
    endtask

    function automatic cfg_t small_cfg();
        cfg_t c;
        c.jerk_impact_level = 23'($urandom_range(200000, 10000));
        c.jerk_still_level  = 23'($urandom_range(30000, 1000));
        c.gyro_moving_level = 16'($urandom_range(1000, 100));
        c.gyro_still_level  = 16'($urandom_range(200, 20));
        c.lift_quiet_limit  = 10'($urandom_range(8));
        c.end_quiet_limit   = 10'($urandom_range(20));
        c.tail_keep_frames  = 10'($urandom_range(30));
        c.min_stroke_frames = 13'($urandom_range(40));
        return c;
    endfunction

    initial
    begin
        cfg_t c;
        sample_t s;
        int phase;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_JERK_IMPACT;
        cfg_data = '0;
        calm = 0;
        sent = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes at reset settings
        send('0);
        send({6{16'sh7fff}});
        send({6{16'sh8000}});
        s = '0; s.accel_x = 16'sh1000; send(s);
        s.gyro_z = 16'sh8000; send(s);                       // full-scale gyro while writing
        s.gyro_z = 16'sh0001; send(s);
        s.accel_x = 16'sh8000; s.accel_y = 16'sh7fff; send(s);
        for (int i = 0; i < 6; i++) send(make_sample(KIND_STILL));
        send(make_sample(KIND_JOLT));
        drain();

        // All-zero settings: no sample counts as quiet, so the pen never lifts
        write_cfg('0);
        stroke(5, 4);
        stroke(3, 6);
        drain();

        // Top settings: nothing can count as active
        c = '1;
        write_cfg(c);
        stroke(6, 4);
        drain();

        // Reset settings, one full-length stroke
        c.jerk_impact_level = 23'd49152; c.jerk_still_level = 23'd8192;
        c.gyro_moving_level = 16'd240;   c.gyro_still_level = 16'd80;
        c.lift_quiet_limit = 10'd50;     c.end_quiet_limit = 10'd200;
        c.tail_keep_frames = 10'd70;     c.min_stroke_frames = 13'd20;
        write_cfg(c);
        calm = 1;
        stroke(30, 260);
        calm = 0;
        drain();

        // Random phases with short quiet limits
        phase = 0;
        while (sent < RANDOM_ITEMS - 60)
        begin
            c = small_cfg();
            write_cfg(c);
            for (int k = 0; k < 6; k++)
            begin
                stroke($urandom_range(20, 1),
                       $urandom_range(c.lift_quiet_limit + c.end_quiet_limit + 6));
                // sender holds off once mid-phase until all results are back
                if (phase == 2 && k == 3)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    while (sb.expected_q.size() != 0) @(posedge clk);
                end
            end
            drain();
            phase++;
        end

        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        $display("%0d samples sent, %0d strokes finished (%0d accepted), %0d full-stroke results",
                 sb.samples_seen, sb.strokes_done, sb.strokes_kept, sb.full_seen);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
